// ===== sv/hsv2rgb_pkg.sv =====
// Shared widths, sector codes, stage payload types and the divide-by-full-scale helper
// for the HSV to RGB converter. Depends on nothing.
package hsv2rgb_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int HUE_BITS       = 16;
    localparam int SECTOR_BITS    = 3;
    localparam int H6_BITS        = HUE_BITS + SECTOR_BITS;
    localparam int PROD_BITS      = COMPONENT_BITS + HUE_BITS;
    localparam int SQ_BITS        = 2 * COMPONENT_BITS;
    localparam int WIDE_BITS      = SQ_BITS + HUE_BITS;

    // Full scale of a component, standing for 1.0.
    localparam logic [COMPONENT_BITS-1:0] COMP_MAX = {COMPONENT_BITS{1'b1}};
    // Full scale times the unit fraction: the common denominator of q and t.
    localparam logic [PROD_BITS-1:0] DEN = {COMP_MAX, {HUE_BITS{1'b0}}};

    typedef logic [COMPONENT_BITS-1:0] comp_t;
    typedef logic [HUE_BITS-1:0]       hue_t;

    typedef enum logic [SECTOR_BITS-1:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t               sector;
        logic                  grey;
        comp_t                 val;
        comp_t                 sat;
        hue_t                  frac;
        logic [HUE_BITS:0]     frac_c;
    } s1_t;

    typedef struct packed {
        sector_t               sector;
        logic                  grey;
        comp_t                 val;
        logic [PROD_BITS-1:0]  sf;
        logic [PROD_BITS-1:0]  sfc;
        logic [SQ_BITS-1:0]    pn;
    } s2_t;

    typedef struct packed {
        sector_t               sector;
        logic                  grey;
        comp_t                 val;
        logic [SQ_BITS-1:0]    pn;
        logic [WIDE_BITS-1:0]  qn;
        logic [WIDE_BITS-1:0]  tn;
    } s3_t;

    typedef struct packed {
        logic s2;
        logic s3;
    } mult_en_t;

    // Floor of x divided by full scale, exact whenever the quotient fits in a component,
    // which covers every product of two components.
    function automatic comp_t div_max(input logic [SQ_BITS-1:0] x);
        logic [SQ_BITS:0] sum;
        sum = {1'b0, x} + {{(COMPONENT_BITS+1){1'b0}}, x[SQ_BITS-1:COMPONENT_BITS]}
              + {{SQ_BITS{1'b0}}, 1'b1};
        return sum[SQ_BITS-1:COMPONENT_BITS];
    endfunction

endpackage

// ===== sv/hsv2rgb_sector.sv =====
// First pipeline stage: hue times six split into sector and fraction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector import hsv2rgb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  hue_t  hue,
    input  comp_t saturation,
    input  comp_t brightness,
    output logic  out_valid,
    output s1_t   out_data
);

    logic               valid_reg;
    s1_t                data_reg;
    s1_t                data_next;
    logic [H6_BITS-1:0] h6;

    always_comb begin
        // Six times the hue as four times plus two times.
        h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        data_next.sector = sector_t'(h6[H6_BITS-1:HUE_BITS]);
        data_next.frac   = h6[HUE_BITS-1:0];
        data_next.frac_c = {1'b1, {HUE_BITS{1'b0}}} - {1'b0, h6[HUE_BITS-1:0]};
        data_next.grey   = (saturation == '0);
        data_next.val    = brightness;
        data_next.sat    = saturation;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/hsv2rgb_mult.sv =====
// Second and third pipeline stages: the saturation products, then the brightness
// products over the common denominator. Depends on hsv2rgb_pkg.
module hsv2rgb_mult import hsv2rgb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mult_en_t en,
    input  logic     in_valid,
    input  s1_t      in_data,
    output logic     s2_valid,
    output logic     out_valid,
    output s3_t      out_data
);

    logic               s2_valid_reg;
    s2_t                s2_reg;
    s2_t                s2_next;
    logic               s3_valid_reg;
    s3_t                s3_reg;
    s3_t                s3_next;
    logic [PROD_BITS:0] sfc_wide;
    logic [PROD_BITS-1:0] qa;
    logic [PROD_BITS-1:0] ta;

    always_comb begin
        s2_next.sector = in_data.sector;
        s2_next.grey   = in_data.grey;
        s2_next.val    = in_data.val;
        s2_next.sf     = PROD_BITS'(in_data.sat) * PROD_BITS'(in_data.frac);
        sfc_wide       = (PROD_BITS+1)'(in_data.sat) * (PROD_BITS+1)'(in_data.frac_c);
        // s*(1-f) never exceeds full scale times one, so the top bit is always clear.
        s2_next.sfc    = sfc_wide[PROD_BITS-1:0];
        s2_next.pn     = SQ_BITS'(in_data.val) * SQ_BITS'(COMP_MAX - in_data.sat);
    end

    always_comb begin
        qa             = DEN - s2_reg.sf;
        ta             = DEN - s2_reg.sfc;
        s3_next.sector = s2_reg.sector;
        s3_next.grey   = s2_reg.grey;
        s3_next.val    = s2_reg.val;
        s3_next.pn     = s2_reg.pn;
        s3_next.qn     = WIDE_BITS'(s2_reg.val) * WIDE_BITS'(qa);
        s3_next.tn     = WIDE_BITS'(s2_reg.val) * WIDE_BITS'(ta);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (en.s2) begin
                s2_valid_reg <= in_valid;
            end
            if (en.s3) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            s2_reg <= s2_next;
        end
        if (en.s3) begin
            s3_reg <= s3_next;
        end
    end

    assign s2_valid  = s2_valid_reg;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

endmodule

// ===== sv/hsv2rgb_select.sv =====
// Last pipeline stage: division by full scale, sector assignment and the output register.
// Depends on hsv2rgb_pkg.
module hsv2rgb_select import hsv2rgb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  s3_t   in_data,
    output logic  out_valid,
    output comp_t red,
    output comp_t green,
    output comp_t blue
);

    logic  valid_reg;
    comp_t red_reg;
    comp_t green_reg;
    comp_t blue_reg;
    comp_t red_next;
    comp_t green_next;
    comp_t blue_next;
    comp_t p;
    comp_t q;
    comp_t t;
    comp_t v;

    always_comb begin
        v = in_data.val;
        p = div_max(in_data.pn);
        // Dropping the fraction bits first leaves the floor unchanged.
        q = div_max(in_data.qn[WIDE_BITS-1:HUE_BITS]);
        t = div_max(in_data.tn[WIDE_BITS-1:HUE_BITS]);
        case (in_data.sector)
            SEC_RED_YELLOW: begin
                red_next = v; green_next = t; blue_next = p;
            end
            SEC_YELLOW_GREEN: begin
                red_next = q; green_next = v; blue_next = p;
            end
            SEC_GREEN_CYAN: begin
                red_next = p; green_next = v; blue_next = t;
            end
            SEC_CYAN_BLUE: begin
                red_next = p; green_next = q; blue_next = v;
            end
            SEC_BLUE_MAGENTA: begin
                red_next = t; green_next = p; blue_next = v;
            end
            default: begin
                red_next = v; green_next = p; blue_next = q;
            end
        endcase
        if (in_data.grey) begin
            red_next   = v;
            green_next = v;
            blue_next  = v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: four-stage pipeline with per-stage valid bits.
// Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_mult and hsv2rgb_select.
//
//  channel | direction | tdata fields, lowest bit first
//  s_      | in        | hue[15:0], saturation[23:16], brightness[31:24]
//  m_      | out       | red[7:0], green[15:8], blue[23:16]
//
// One word is taken per clock while m_tready is high; an accepted word passes through
// the register stages hue sector, saturation products, brightness products, and then
// division and sector assignment in the output register.
// aresetn clears the valid bits only; the pipeline is empty after reset.
// A stage advances when it is empty or the stage after it advances, so bubbles close up
// while m_tready is low and nothing is lost or repeated.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic     en1;
    logic     en_out;
    mult_en_t mult_en;
    logic     s1_valid;
    s1_t      s1_data;
    logic     s2_valid;
    logic     s3_valid;
    s3_t      s3_data;
    comp_t    red;
    comp_t    green;
    comp_t    blue;

    always_comb begin
        en_out     = !m_tvalid || m_tready;
        mult_en.s3 = !s3_valid || en_out;
        mult_en.s2 = !s2_valid || mult_en.s3;
        en1        = !s1_valid || mult_en.s2;
    end

    assign s_tready = en1;

    hsv2rgb_sector u_sector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en1),
        .in_valid   (s_tvalid),
        .hue        (s_tdata[15:0]),
        .saturation (s_tdata[23:16]),
        .brightness (s_tdata[31:24]),
        .out_valid  (s1_valid),
        .out_data   (s1_data)
    );

    hsv2rgb_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (mult_en),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .s2_valid  (s2_valid),
        .out_valid (s3_valid),
        .out_data  (s3_data)
    );

    hsv2rgb_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_out),
        .in_valid  (s3_valid),
        .in_data   (s3_data),
        .out_valid (m_tvalid),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red};

    // A free output must open the whole pipeline to the input.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output was free");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown straight after reset");

    // A taken result with nothing behind it must not be shown again.
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !s3_valid) |=> !m_tvalid)
        else $error("result repeated after it was taken");

endmodule
